/* rtl/playfair_digraph_decrypt_top_assert.svh */
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt_top_assert
// Assertion macros for the Playfair digraph decrypt block.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_DECRYPT_TOP_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_DECRYPT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfd assertion failed");

// Next-cycle implication, disabled while in reset.
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfd assertion failed");

`endif

/* rtl/pfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_pkg
// Types, constants and the reset layout for the Playfair digraph decrypt block.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int SIDE_DEF = 5;
  localparam int LETTER_W = 5;
  localparam int COORD_W  = 3;
  localparam int W_CODE   = 22;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [COORD_W-1:0]  coord_t;

  typedef enum logic {
    ACT_DECRYPT = 1'b0,
    ACT_SWAP    = 1'b1
  } action_t;

  typedef struct packed {
    logic   en;
    coord_t row_a;
    coord_t col_a;
    coord_t row_b;
    coord_t col_b;
  } swap_req_t;

  typedef struct packed {
    letter_t plain_first;
    letter_t plain_second;
    logic    bad_letter;
  } lookup_t;

  // Reset layout: alphabet without W, reversed, row-major.
  function automatic int reset_letter(input int idx, input int cells);
    int pos;
    pos = cells - 1 - idx;
    return (pos >= W_CODE) ? pos + 1 : pos;
  endfunction

endpackage

/* rtl/pfd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_if
// Valid/ready channels for decode or swap items and for plaintext results.
// ----------------------------------------------------------------------------
interface pfd_in_if import pfd_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    action;
  letter_t first_letter;
  letter_t second_letter;
  coord_t  row_a;
  coord_t  col_a;
  coord_t  row_b;
  coord_t  col_b;

  modport source (output valid, action, first_letter, second_letter,
                  row_a, col_a, row_b, col_b, input ready);
  modport sink   (input valid, action, first_letter, second_letter,
                  row_a, col_a, row_b, col_b, output ready);
endinterface

interface pfd_out_if import pfd_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t plain_first;
  letter_t plain_second;
  logic    bad_letter;

  modport source (output valid, plain_first, plain_second, bad_letter, input ready);
  modport sink   (input valid, plain_first, plain_second, bad_letter, output ready);
endinterface

/* rtl/pfd_square.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_square
// Key square register with cell swap and combinational digraph lookup.
// ----------------------------------------------------------------------------
module pfd_square import pfd_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  swap_req_t swap_req,
  input  letter_t   first_letter,
  input  letter_t   second_letter,
  output lookup_t   lookup
);

  localparam int CELLS = SIDE * SIDE;

  letter_t sq_r   [CELLS];
  letter_t sq_nxt [CELLS];

  logic [CELLS-1:0] match1, match2;
  logic [CELLS-1:0] wa, wb;
  logic [CELLS-1:0] sel_col1, sel_col2, sel_row1, sel_row2, sel_rect1, sel_rect2;
  logic [CELLS-1:0] sel1, sel2;
  logic [SIDE-1:0]  rh1, rh2, ch1, ch2;
  logic             found1, found2, same_col, same_row, swap_ok;
  letter_t          cell_a, cell_b, p1, p2;

  // Per-cell match, swap decode and neighbor selects, all at fixed taps.
  for (genvar r = 0; r < SIDE; r++) begin : g_row
    for (genvar k = 0; k < SIDE; k++) begin : g_col
      localparam int J     = r * SIDE + k;
      localparam int BELOW = ((r + 1) % SIDE) * SIDE + k;
      localparam int RIGHT = r * SIDE + (k + 1) % SIDE;
      assign match1[J]    = (sq_r[J] == first_letter);
      assign match2[J]    = (sq_r[J] == second_letter);
      assign wa[J]        = (swap_req.row_a == COORD_W'(r)) && (swap_req.col_a == COORD_W'(k));
      assign wb[J]        = (swap_req.row_b == COORD_W'(r)) && (swap_req.col_b == COORD_W'(k));
      assign sel_col1[J]  = match1[BELOW];
      assign sel_col2[J]  = match2[BELOW];
      assign sel_row1[J]  = match1[RIGHT];
      assign sel_row2[J]  = match2[RIGHT];
      assign sel_rect1[J] = rh1[r] & ch2[k];
      assign sel_rect2[J] = rh2[r] & ch1[k];
    end
  end

  always_comb begin
    rh1 = '0;
    rh2 = '0;
    ch1 = '0;
    ch2 = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int k = 0; k < SIDE; k++) begin
        rh1[r] = rh1[r] | match1[r*SIDE + k];
        rh2[r] = rh2[r] | match2[r*SIDE + k];
        ch1[k] = ch1[k] | match1[r*SIDE + k];
        ch2[k] = ch2[k] | match2[r*SIDE + k];
      end
    end
  end

  assign found1   = |match1;
  assign found2   = |match2;
  assign same_col = (ch1 == ch2);
  assign same_row = (rh1 == rh2);

  // Column rule wins, so a doubled letter takes the letter above.
  always_comb begin
    if (same_col) begin
      sel1 = sel_col1;
      sel2 = sel_col2;
    end else if (same_row) begin
      sel1 = sel_row1;
      sel2 = sel_row2;
    end else begin
      sel1 = sel_rect1;
      sel2 = sel_rect2;
    end
  end

  always_comb begin
    p1     = '0;
    p2     = '0;
    cell_a = '0;
    cell_b = '0;
    for (int j = 0; j < CELLS; j++) begin
      p1     = p1     | (sel1[j] ? sq_r[j] : '0);
      p2     = p2     | (sel2[j] ? sq_r[j] : '0);
      cell_a = cell_a | (wa[j]   ? sq_r[j] : '0);
      cell_b = cell_b | (wb[j]   ? sq_r[j] : '0);
    end
  end

  always_comb begin
    if (found1 && found2) begin
      lookup.plain_first  = p1;
      lookup.plain_second = p2;
      lookup.bad_letter   = 1'b0;
    end else begin
      lookup.plain_first  = '0;
      lookup.plain_second = '0;
      lookup.bad_letter   = 1'b1;
    end
  end

  // Drop a swap with any coordinate off the square.
  assign swap_ok = swap_req.en &&
                   (int'(swap_req.row_a) < SIDE) && (int'(swap_req.col_a) < SIDE) &&
                   (int'(swap_req.row_b) < SIDE) && (int'(swap_req.col_b) < SIDE);

  always_comb begin
    for (int j = 0; j < CELLS; j++) begin
      if (swap_ok && wa[j]) begin
        sq_nxt[j] = cell_b;
      end else if (swap_ok && wb[j]) begin
        sq_nxt[j] = cell_a;
      end else begin
        sq_nxt[j] = sq_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < CELLS; j++) begin
        sq_r[j] <= letter_t'(reset_letter(j, CELLS));
      end
    end else begin
      sq_r <= sq_nxt;
    end
  end

endmodule

/* rtl/playfair_digraph_decrypt_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_decrypt_top
// Playfair digraph decryption over a key square that swap items can reorder.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while no decrypt item waits on a stalled
// result register: a decrypt item yields one plaintext pair through the input
// register, then the result register; a swap item yields nothing and reorders
// the key square at the end of its stage cycle, so the very next item already
// sees the new layout. The rate is set by the combinational key square lookup:
// letter positions are found by matching all cells at once, and the result
// letter is picked from fixed neighbor taps. A stalled result register holds a
// decrypt item in the input stage; swap items pass on regardless. After reset
// the square holds the alphabet without W in reverse order; a letter not in the
// square (W or a code above Z) returns bad_letter with both letters zero.
`include "playfair_digraph_decrypt_top_assert.svh"

module playfair_digraph_decrypt_top import pfd_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pfd_in_if.sink      in_chan,
  pfd_out_if.source   out_chan
);

  logic      stg_v_r, stg_v_nxt;
  logic      stg_act_r;
  letter_t   stg_first_r, stg_second_r;
  coord_t    stg_row_a_r, stg_col_a_r, stg_row_b_r, stg_col_b_r;
  logic      stg_is_swap, stg_adv, dec_adv;
  logic      out_v_r, out_v_nxt;
  lookup_t   out_r;
  lookup_t   lookup;
  swap_req_t swap_req;

  assign stg_is_swap = (stg_act_r == ACT_SWAP);
  assign stg_adv     = stg_v_r && (stg_is_swap || !out_v_r || out_chan.ready);
  assign dec_adv     = stg_adv && !stg_is_swap;
  assign in_chan.ready = !stg_v_r || stg_adv;

  assign stg_v_nxt = in_chan.valid ? 1'b1 : (stg_adv ? 1'b0 : stg_v_r);
  assign out_v_nxt = dec_adv ? 1'b1 : (out_chan.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      // Stage only changes on transfer or advance; ready gates the input.
      if (in_chan.ready) begin
        stg_v_r <= stg_v_nxt;
      end
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      stg_act_r    <= in_chan.action;
      stg_first_r  <= in_chan.first_letter;
      stg_second_r <= in_chan.second_letter;
      stg_row_a_r  <= in_chan.row_a;
      stg_col_a_r  <= in_chan.col_a;
      stg_row_b_r  <= in_chan.row_b;
      stg_col_b_r  <= in_chan.col_b;
    end
    if (dec_adv) begin
      out_r <= lookup;
    end
  end

  always_comb begin
    swap_req.en    = stg_adv && stg_is_swap;
    swap_req.row_a = stg_row_a_r;
    swap_req.col_a = stg_col_a_r;
    swap_req.row_b = stg_row_b_r;
    swap_req.col_b = stg_col_b_r;
  end

  pfd_square #(
    .SIDE (SIDE)
  ) u_square (
    .clk           (clk),
    .rst_n         (rst_n),
    .swap_req      (swap_req),
    .first_letter  (stg_first_r),
    .second_letter (stg_second_r),
    .lookup        (lookup)
  );

  assign out_chan.valid        = out_v_r;
  assign out_chan.plain_first  = out_r.plain_first;
  assign out_chan.plain_second = out_r.plain_second;
  assign out_chan.bad_letter   = out_r.bad_letter;

  `PFD_ASSERT_NOW(a_bad_zero, clk, rst_n, out_v_r && out_r.bad_letter,
                  out_r.plain_first == '0 && out_r.plain_second == '0)
  `PFD_ASSERT_NEXT(a_dec_result, clk, rst_n, dec_adv, out_v_r)
  `PFD_ASSERT_NEXT(a_swap_silent, clk, rst_n, stg_adv && stg_is_swap,
                   out_v_r == $past(out_v_r && !out_chan.ready))
  `PFD_ASSERT_NOW(a_stall_held, clk, rst_n, !in_chan.ready,
                  stg_v_r && !stg_is_swap && out_v_r)

endmodule

/* tb/tb_playfair_digraph_decrypt_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_playfair_digraph_decrypt_top
// Self-checking bench for the Playfair digraph decrypt block. Directed pairs
// hit each cipher rule, absent letters and the swap corner cases. Random
// traffic then mixes decrypts and square swaps under several idle/stall
// patterns. A local model of the key square predicts every plaintext pair.
// ----------------------------------------------------------------------------
module tb_playfair_digraph_decrypt_top;
  import pfd_pkg::*;

  localparam int    SIDE       = SIDE_DEF;
  localparam int    CELLS      = SIDE * SIDE;
  localparam int    LETTERS    = 26;
  localparam int    QUIET_MAX  = 2000;
  localparam int    DRAIN_WAIT = 8;
  localparam int    SHOW_MAX   = 10;
  localparam string NO_W_ORDER = "ABCDEFGHIJKLMNOPQRSTUVXYZ";

  typedef struct {
    action_t action;
    letter_t first_letter;
    letter_t second_letter;
    coord_t  row_a;
    coord_t  col_a;
    coord_t  row_b;
    coord_t  col_b;
  } cipher_item_t;

  logic clk = 1'b0;
  logic rst_n;

  pfd_in_if  in_chan ();
  pfd_out_if out_chan ();

  playfair_digraph_decrypt_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the key square and of every letter's position.
  letter_t square [CELLS];
  coord_t  pos_row [LETTERS];
  coord_t  pos_col [LETTERS];

  lookup_t plain_pending [$];

  int src_idle_pct;
  int snk_stall_pct;
  int errors;
  int decodes_sent;
  int swaps_sent;
  int swaps_ignored;
  int bad_results;
  int results_seen;

  function automatic letter_t ltr(input byte ch);
    return letter_t'(ch - "A");
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= SHOW_MAX) $display("ERROR: %s", msg);
  endfunction

  function automatic void load_reset_square();
    int code;
    for (int i = 0; i < LETTERS; i++) begin
      pos_row[i] = 3'd7;
      pos_col[i] = 3'd7;
    end
    for (int i = 0; i < CELLS; i++) begin
      code = NO_W_ORDER[CELLS - 1 - i] - "A";
      square[i] = letter_t'(code);
      pos_row[code] = coord_t'(i / SIDE);
      pos_col[code] = coord_t'(i % SIDE);
    end
  endfunction

  function automatic bit on_square(input letter_t c);
    if (c >= LETTERS) return 1'b0;
    return pos_row[c] < SIDE && pos_col[c] < SIDE;
  endfunction

  function automatic lookup_t decode_pair(input letter_t c1, input letter_t c2);
    lookup_t res;
    int r1, k1, r2, k2;
    res = '0;
    if (!on_square(c1) || !on_square(c2)) begin
      res.bad_letter = 1'b1;
      return res;
    end
    r1 = pos_row[c1];
    k1 = pos_col[c1];
    r2 = pos_row[c2];
    k2 = pos_col[c2];
    if (k1 == k2) begin
      res.plain_first  = square[((r1 + SIDE - 1) % SIDE) * SIDE + k1];
      res.plain_second = square[((r2 + SIDE - 1) % SIDE) * SIDE + k2];
    end else if (r1 == r2) begin
      res.plain_first  = square[r1 * SIDE + (k1 + SIDE - 1) % SIDE];
      res.plain_second = square[r2 * SIDE + (k2 + SIDE - 1) % SIDE];
    end else begin
      res.plain_first  = square[r1 * SIDE + k2];
      res.plain_second = square[r2 * SIDE + k1];
    end
    return res;
  endfunction

  function automatic void apply_cell_swap(input cipher_item_t it);
    int ia, ib;
    letter_t la, lb;
    if (it.row_a >= SIDE || it.col_a >= SIDE || it.row_b >= SIDE || it.col_b >= SIDE) begin
      swaps_ignored++;
      return;
    end
    ia = it.row_a * SIDE + it.col_a;
    ib = it.row_b * SIDE + it.col_b;
    la = square[ia];
    lb = square[ib];
    pos_row[la] = it.row_b;
    pos_col[la] = it.col_b;
    pos_row[lb] = it.row_a;
    pos_col[lb] = it.col_a;
    square[ia] = lb;
    square[ib] = la;
  endfunction

  // Unused fields of each item get random values so that the block must ignore them.
  function automatic cipher_item_t make_decode(input letter_t c1, input letter_t c2);
    cipher_item_t it;
    it.action        = ACT_DECRYPT;
    it.first_letter  = c1;
    it.second_letter = c2;
    it.row_a = coord_t'($urandom_range(0, 7));
    it.col_a = coord_t'($urandom_range(0, 7));
    it.row_b = coord_t'($urandom_range(0, 7));
    it.col_b = coord_t'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic cipher_item_t make_swap(input int ra, input int ca, input int rb,
                                             input int cb);
    cipher_item_t it;
    it.action        = ACT_SWAP;
    it.first_letter  = letter_t'($urandom_range(0, 31));
    it.second_letter = letter_t'($urandom_range(0, 31));
    it.row_a = coord_t'(ra);
    it.col_a = coord_t'(ca);
    it.row_b = coord_t'(rb);
    it.col_b = coord_t'(cb);
    return it;
  endfunction

  function automatic letter_t pick_letter();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return letter_t'($urandom_range(LETTERS, 31));
    if (roll < 9) return ltr("W");
    return square[$urandom_range(0, CELLS - 1)];
  endfunction

  function automatic cipher_item_t random_item();
    letter_t c1, c2;
    int roll;
    if ($urandom_range(0, 99) < 30) begin
      // Mostly in-range cells, some with out-of-range coordinates.
      if ($urandom_range(0, 9) == 0)
        return make_swap($urandom_range(0, 7), $urandom_range(0, 7),
                         $urandom_range(0, 7), $urandom_range(0, 7));
      return make_swap($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                       $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1));
    end
    c1 = pick_letter();
    roll = $urandom_range(0, 99);
    // Bias toward pairs that share a row, a column, or the same letter.
    if (on_square(c1) && roll < 20)
      c2 = square[pos_row[c1] * SIDE + $urandom_range(0, SIDE - 1)];
    else if (on_square(c1) && roll < 40)
      c2 = square[$urandom_range(0, SIDE - 1) * SIDE + pos_col[c1]];
    else if (roll < 45)
      c2 = c1;
    else
      c2 = pick_letter();
    return make_decode(c1, c2);
  endfunction

  // Drive one item and hold it until its transfer, then update the prediction.
  task automatic send_item(input cipher_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.action        <= it.action;
    in_chan.first_letter  <= it.first_letter;
    in_chan.second_letter <= it.second_letter;
    in_chan.row_a         <= it.row_a;
    in_chan.col_a         <= it.col_a;
    in_chan.row_b         <= it.row_b;
    in_chan.col_b         <= it.col_b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (it.action == ACT_SWAP) begin
      swaps_sent++;
      apply_cell_swap(it);
    end else begin
      decodes_sent++;
      plain_pending.push_back(decode_pair(it.first_letter, it.second_letter));
    end
  endtask

  task automatic test_cipher_rules();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_item(make_decode(ltr("Z"), ltr("T")));   // same column, wraps to bottom row
    send_item(make_decode(ltr("P"), ltr("A")));   // same column at the right edge
    send_item(make_decode(ltr("Z"), ltr("U")));   // same row, wraps to right edge
    send_item(make_decode(ltr("K"), ltr("M")));   // same row, middle
    send_item(make_decode(ltr("Z"), ltr("P")));   // rectangle
    send_item(make_decode(ltr("A"), ltr("Z")));   // lowest and highest codes
    send_item(make_decode(ltr("A"), ltr("A")));   // doubled letter
    send_item(make_decode(ltr("Z"), ltr("Z")));
  endtask

  task automatic test_absent_letters();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_item(make_decode(ltr("W"), ltr("A")));
    send_item(make_decode(ltr("A"), ltr("W")));
    send_item(make_decode(ltr("W"), ltr("W")));
    send_item(make_decode(letter_t'(LETTERS), ltr("B")));
    send_item(make_decode(ltr("C"), letter_t'(31)));
    send_item(make_decode(letter_t'(31), letter_t'(30)));
  endtask

  task automatic test_square_swaps();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_item(make_swap(SIDE, 0, 0, 1));          // each coordinate out of range in turn
    send_item(make_swap(0, 7, 0, 1));
    send_item(make_swap(0, 0, 6, 1));
    send_item(make_swap(0, 0, 1, SIDE));
    send_item(make_decode(ltr("Z"), ltr("Y")));
    send_item(make_swap(2, 2, 2, 2));             // cell with itself
    send_item(make_decode(ltr("M"), ltr("N")));
    send_item(make_swap(0, 0, SIDE - 1, SIDE - 1)); // opposite corners
    send_item(make_decode(ltr("Z"), ltr("A")));
    send_item(make_swap(1, 3, 3, 1));             // back-to-back swaps then decode
    send_item(make_swap(1, 3, 1, 4));
    send_item(make_decode(ltr("Q"), ltr("I")));
  endtask

  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int count);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    repeat (count) send_item(random_item());
  endtask

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin : result_check
    lookup_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (out_chan.bad_letter === 1'b1) bad_results++;
      if (plain_pending.size() == 0) begin
        note_error($sformatf("unexpected result: first=%0d second=%0d bad=%0d",
                             out_chan.plain_first, out_chan.plain_second,
                             out_chan.bad_letter));
      end else begin
        want = plain_pending.pop_front();
        if (out_chan.plain_first !== want.plain_first ||
            out_chan.plain_second !== want.plain_second ||
            out_chan.bad_letter !== want.bad_letter)
          note_error($sformatf(
            "result %0d: exp first=%0d second=%0d bad=%0d, got first=%0d second=%0d bad=%0d",
            results_seen, want.plain_first, want.plain_second, want.bad_letter,
            out_chan.plain_first, out_chan.plain_second, out_chan.bad_letter));
      end
    end
  end

  // End the run after too many cycles without a transfer on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if (rst_n && !(in_chan.valid && in_chan.ready) && !(out_chan.valid && out_chan.ready))
        quiet++;
      else
        quiet = 0;
    end
    $display("watchdog: %0d quiet cycles, %0d results outstanding", quiet,
             plain_pending.size());
    $display("FAIL playfair_digraph_decrypt_top");
    $finish;
  end

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.action        = ACT_DECRYPT;
    in_chan.first_letter  = '0;
    in_chan.second_letter = '0;
    in_chan.row_a         = '0;
    in_chan.col_a         = '0;
    in_chan.row_b         = '0;
    in_chan.col_b         = '0;
    src_idle_pct          = 0;
    snk_stall_pct         = 0;
    errors                = 0;
    decodes_sent          = 0;
    swaps_sent            = 0;
    swaps_ignored         = 0;
    bad_results           = 0;
    results_seen          = 0;
    load_reset_square();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_cipher_rules();
    test_absent_letters();
    test_square_swaps();
    test_random_traffic(0, 0, 125);
    test_random_traffic(88, 0, 125);
    test_random_traffic(0, 88, 125);
    test_random_traffic(9, 9, 125);

    in_chan.valid <= 1'b0;
    while (plain_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (plain_pending.size() != 0)
      note_error($sformatf("%0d expected results never arrived", plain_pending.size()));

    $display("Covered %0d decrypt pairs (%0d flagged bad) and %0d swaps (%0d out of range).",
             decodes_sent, bad_results, swaps_sent, swaps_ignored);
    $display("Checked %0d results across four idle/stall patterns; %0d errors.",
             results_seen, errors);
    if (errors == 0) begin
      $display("PASS playfair_digraph_decrypt_top");
    end else begin
      $display("FAIL playfair_digraph_decrypt_top");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/pfd_pkg.sv
rtl/pfd_if.sv
rtl/pfd_square.sv
rtl/playfair_digraph_decrypt_top.sv
tb/tb_playfair_digraph_decrypt_top.sv
